[rtl/sm4_block_cipher_defines.svh]
// Assertion macros for the SM4 block cipher RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTH
`define SM4_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sm4 assertion failed");
`define SM4_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("sm4 assertion failed");
`else
`define SM4_ASSERT(name, clk, rst, prop)
`define SM4_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[rtl/sm4_pkg.sv]
// Shared types, constants and round functions of the SM4 block cipher.
// Used by every module of the block; depends on nothing.
package sm4_pkg;

   localparam int ROUNDS   = 32;
   localparam int RK_IDX_W = $clog2(ROUNDS);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd1;

   localparam logic [31:0] FK0 = 32'hA3B1BAC6;
   localparam logic [31:0] FK1 = 32'h56AA3350;
   localparam logic [31:0] FK2 = 32'h677D9197;
   localparam logic [31:0] FK3 = 32'hB27022DC;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic        mode;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] x0;
      logic [31:0] x1;
      logic [31:0] x2;
      logic [31:0] x3;
   } state_type;

   typedef logic [ROUNDS-1:0][31:0] rk_array_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic logic [31:0] tau(input logic [31:0] a);
      tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
   endfunction

   function automatic logic [31:0] t_data(input logic [31:0] a);
      logic [31:0] b;
      b = tau(a);
      t_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   function automatic logic [31:0] t_key(input logic [31:0] a);
      logic [31:0] b;
      b = tau(a);
      t_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] idx);
      logic [7:0] pos;
      logic [7:0] prod;
      ck_word = '0;
      for (int j = 0; j < 4; j++) begin
         pos  = {1'b0, idx, 2'(j)};
         prod = 8'({pos, 3'b000} - pos);
         ck_word = {ck_word[23:0], prod};
      end
   endfunction

endpackage

[rtl/sm4_key_expand.sv]
// SM4 key registers and iterative key schedule, one round key per cycle.
// Depends on sm4_pkg and sm4_block_cipher_defines.svh.
`include "sm4_block_cipher_defines.svh"
module sm4_key_expand
   import sm4_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data,
   output logic                 busy,
   output rk_array_type         round_keys
);

   logic [63:0]         key_high_ff, key_high_in;
   logic [63:0]         key_low_ff, key_low_in;
   logic [3:0][31:0]    k_ff, k_in;
   logic [RK_IDX_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   rk_array_type        rk_ff;
   logic                csr_write;
   logic                key_write;
   logic [31:0]         nk;

   assign csr_ready  = !busy_ff;
   assign busy       = busy_ff;
   assign round_keys = rk_ff;
   assign csr_write  = csr_valid && csr_ready;

   always_comb begin
      key_write   = 1'b0;
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      unique case (csr_index)
         CSR_KEY_HIGH: begin
            key_write   = csr_write;
            key_high_in = csr_write ? csr_data : key_high_ff;
         end
         CSR_KEY_LOW: begin
            key_write  = csr_write;
            key_low_in = csr_write ? csr_data : key_low_ff;
         end
         default: begin
            key_write = 1'b0;
         end
      endcase
   end

   assign nk = k_ff[0] ^ t_key(k_ff[1] ^ k_ff[2] ^ k_ff[3] ^ ck_word(cnt_ff));

   always_comb begin
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (key_write) begin
         k_in[0] = key_high_in[63:32] ^ FK0;
         k_in[1] = key_high_in[31:0]  ^ FK1;
         k_in[2] = key_low_in[63:32]  ^ FK2;
         k_in[3] = key_low_in[31:0]   ^ FK3;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         k_in    = {nk, k_ff[3], k_ff[2], k_ff[1]};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != RK_IDX_W'(ROUNDS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         cnt_ff      <= '0;
         busy_ff     <= 1'b0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         cnt_ff      <= cnt_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (busy_ff) begin
         rk_ff[cnt_ff] <= nk;
      end
   end

   `SM4_ASSERT(a_key_write_starts, clock, reset,
      (csr_valid && csr_ready && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW))
      |=> busy_ff)
   `SM4_ASSERT(a_bad_index_ignored, clock, reset,
      (csr_valid && csr_ready && csr_index != CSR_KEY_HIGH && csr_index != CSR_KEY_LOW)
      |=> !busy_ff)
   `SM4_ASSERT(a_expand_length, clock, reset,
      $rose(busy_ff) |-> ##(ROUNDS - 1) (busy_ff && cnt_ff == RK_IDX_W'(ROUNDS - 1)))
   `SM4_ASSERT_ALWAYS(a_count_idle, clock, !busy_ff |-> cnt_ff == '0)

endmodule

[rtl/sm4_round.sv]
// One registered SM4 round: mix three words with the round key, substitute,
// diffuse and fold into the fourth word. Depends on sm4_pkg.
module sm4_round
   import sm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  state_type   in_state,
   input  logic [31:0] rk,
   output logic        out_valid,
   output state_type   out_state
);

   logic      valid_ff;
   state_type state_ff, state_in;

   always_comb begin
      state_in.mode = in_state.mode;
      state_in.x0   = in_state.x1;
      state_in.x1   = in_state.x2;
      state_in.x2   = in_state.x3;
      state_in.x3   = in_state.x0 ^ t_data(in_state.x1 ^ in_state.x2 ^ in_state.x3 ^ rk);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

[rtl/sm4_block_cipher.sv]
// SM4 block cipher top level: key schedule plus a fully unrolled round pipeline.
// Depends on sm4_pkg, sm4_key_expand, sm4_round and sm4_block_cipher_defines.svh.
//
//   channel   handshake               payload
//   request   start, busy             req_data  (req_type)
//   response  rsp_valid (strobe)      rsp_data  (rsp_type)
//   csr       csr_valid, csr_ready    csr_index, csr_data
//
// One block enters per cycle while busy is low; its result leaves the round pipeline, one round per stage.
// A key register write runs the key schedule, one round key per cycle;
// busy and csr_ready hold the request and csr channels off until it ends.
// Synchronous reset clears the valid bits and the key registers; round keys are
// undefined until the first key write. The response side has no stall.
`include "sm4_block_cipher_defines.svh"
module sm4_block_cipher
   import sm4_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_data
);

   rk_array_type round_keys;
   logic         stage_valid [ROUNDS+1];
   state_type    stage_state [ROUNDS+1];
   state_type    last_state;

   sm4_key_expand u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .busy       (busy),
      .round_keys (round_keys)
   );

   assign stage_valid[0]       = start && !busy;
   assign stage_state[0].mode  = req_data.mode;
   assign stage_state[0].x0    = req_data.block_high[63:32];
   assign stage_state[0].x1    = req_data.block_high[31:0];
   assign stage_state[0].x2    = req_data.block_low[63:32];
   assign stage_state[0].x3    = req_data.block_low[31:0];

   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      logic [31:0] rk_sel;

      assign rk_sel = stage_state[i].mode ? round_keys[ROUNDS-1-i] : round_keys[i];

      sm4_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_state  (stage_state[i]),
         .rk        (rk_sel),
         .out_valid (stage_valid[i+1]),
         .out_state (stage_state[i+1])
      );
   end

   assign last_state           = stage_state[ROUNDS];
   assign rsp_valid            = stage_valid[ROUNDS];
   assign rsp_data.result_high = {last_state.x3, last_state.x2};
   assign rsp_data.result_low  = {last_state.x1, last_state.x0};

   `SM4_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##(ROUNDS) rsp_valid)
   `SM4_ASSERT(a_no_spurious_rsp, clock, reset,
      rsp_valid |-> $past(start && !busy, ROUNDS))
   `SM4_ASSERT_ALWAYS(a_csr_blocked_when_busy, clock, busy |-> !csr_ready)

endmodule

[tb/tb_sm4_block_cipher.sv]
`timescale 1ns / 100ps
// Self-checking bench for sm4_block_cipher: directed and random blocks under several keys,
// each result compared with an in-bench SM4 key schedule and round function.
// Depends on sm4_pkg and the sm4_block_cipher RTL.
module tb_sm4_block_cipher;
   import sm4_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_NEEDED  = 4;
   localparam int CIPHER_ROUNDS = 32;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [63:0] ALL_ZERO = 64'h0;
   localparam logic [63:0] ALL_ONE  = 64'hffff_ffff_ffff_ffff;

   localparam logic [7:0] SUBST_BOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam logic [31:0] FAMILY_KEY [4] = '{
      32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
   };

   typedef enum logic {OP_BLOCK, OP_KEY_WRITE} op_kind_type;

   typedef struct {
      op_kind_type             kind;
      req_type                 block;
      logic [CSR_IDX_W-1:0]    index;
      logic [63:0]             value;
      int                      gap;
   } pending_op_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KEY_HIGH;
   logic [63:0]          csr_data  = '0;

   pending_op_type stimulus_queue [$];
   rsp_type        expected_blocks [$];

   logic [63:0] cipher_key_high = '0;
   logic [63:0] cipher_key_low  = '0;
   logic [31:0] cipher_round_keys [CIPHER_ROUNDS];

   bit burst_mode;
   int idle_left;
   int quiet_cycles;
   int mismatch_count;
   int cycle_count;

   sm4_block_cipher uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic logic [31:0] substitute(input logic [31:0] w);
      return {SUBST_BOX[w[31:24]], SUBST_BOX[w[23:16]], SUBST_BOX[w[15:8]], SUBST_BOX[w[7:0]]};
   endfunction

   function automatic logic [31:0] mix_data(input logic [31:0] w);
      logic [31:0] b;
      b = substitute(w);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic logic [31:0] mix_key(input logic [31:0] w);
      logic [31:0] b;
      b = substitute(w);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   function automatic logic [31:0] chain_constant(input int round);
      logic [31:0] w;
      int j;
      w = '0;
      for (j = 0; j < 4; j++)
         w = {w[23:0], 8'(((4 * round + j) * 7) & 255)};
      return w;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] k0, k1, k2, k3, nk;
      int i;
      k0 = cipher_key_high[63:32] ^ FAMILY_KEY[0];
      k1 = cipher_key_high[31:0]  ^ FAMILY_KEY[1];
      k2 = cipher_key_low[63:32]  ^ FAMILY_KEY[2];
      k3 = cipher_key_low[31:0]   ^ FAMILY_KEY[3];
      for (i = 0; i < CIPHER_ROUNDS; i++) begin
         nk = k0 ^ mix_key(k1 ^ k2 ^ k3 ^ chain_constant(i));
         cipher_round_keys[i] = nk;
         k0 = k1;
         k1 = k2;
         k2 = k3;
         k3 = nk;
      end
   endfunction

   function automatic void apply_key_write(input logic [CSR_IDX_W-1:0] index,
                                           input logic [63:0] value);
      if (index == CSR_KEY_HIGH) begin
         cipher_key_high = value;
         expand_round_keys();
      end else if (index == CSR_KEY_LOW) begin
         cipher_key_low = value;
         expand_round_keys();
      end
   endfunction

   function automatic rsp_type sm4_transform(input req_type blk);
      logic [31:0] x0, x1, x2, x3, rk, nx;
      rsp_type out;
      int i;
      x0 = blk.block_high[63:32];
      x1 = blk.block_high[31:0];
      x2 = blk.block_low[63:32];
      x3 = blk.block_low[31:0];
      for (i = 0; i < CIPHER_ROUNDS; i++) begin
         rk = (blk.mode == MODE_DECRYPT) ? cipher_round_keys[CIPHER_ROUNDS - 1 - i]
                                         : cipher_round_keys[i];
         nx = x0 ^ mix_data(x1 ^ x2 ^ x3 ^ rk);
         x0 = x1;
         x1 = x2;
         x2 = x3;
         x3 = nx;
      end
      out.result_high = {x3, x2};
      out.result_low  = {x1, x0};
      return out;
   endfunction

   function automatic int draw_gap();
      if (burst_mode)
         return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic queue_block(input logic [63:0] high, input logic [63:0] low,
                              input logic mode);
      pending_op_type op;
      op.kind             = OP_BLOCK;
      op.block.block_high = high;
      op.block.block_low  = low;
      op.block.mode       = mode;
      op.index            = CSR_KEY_HIGH;
      op.value            = '0;
      op.gap              = draw_gap();
      stimulus_queue.push_back(op);
   endtask

   task automatic queue_key_write(input logic [CSR_IDX_W-1:0] index, input logic [63:0] value);
      pending_op_type op;
      op.kind  = OP_KEY_WRITE;
      op.block = '0;
      op.index = index;
      op.value = value;
      op.gap   = draw_gap();
      stimulus_queue.push_back(op);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   always @(posedge clock) begin : request_driver
      logic start_next;
      logic csr_next;
      pending_op_type op;
      if (reset) begin
         start        <= 1'b0;
         csr_valid    <= 1'b0;
         idle_left    = 0;
         quiet_cycles = 0;
      end else begin
         start_next = start;
         csr_next   = csr_valid;
         if (start && !busy) begin
            expected_blocks.push_back(sm4_transform(req_data));
            start_next = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            apply_key_write(csr_index, csr_data);
            csr_next = 1'b0;
         end
         quiet_cycles = (expected_blocks.size() == 0) ? quiet_cycles + 1 : 0;
         if (!start_next && !csr_next) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (stimulus_queue.size() > 0) begin
               if (stimulus_queue[0].kind == OP_BLOCK) begin
                  op = stimulus_queue.pop_front();
                  req_data   <= op.block;
                  start_next = 1'b1;
                  idle_left  = op.gap;
               end else if (quiet_cycles >= QUIET_NEEDED) begin
                  op = stimulus_queue.pop_front();
                  csr_index <= op.index;
                  csr_data  <= op.value;
                  csr_next  = 1'b1;
                  idle_left = op.gap;
               end
            end
         end
         start     <= start_next;
         csr_valid <= csr_next;
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            $error("result transaction with nothing expected: %h %h",
                   rsp_data.result_high, rsp_data.result_low);
            mismatch_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_data.result_high !== want.result_high) begin
               $error("result_high: expected %h, actual %h",
                      want.result_high, rsp_data.result_high);
               mismatch_count++;
            end
            if (rsp_data.result_low !== want.result_low) begin
               $error("result_low: expected %h, actual %h",
                      want.result_low, rsp_data.result_low);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [63:0] high, low;
      int p, n;

      // directed: half-written key, standard vector, spare indexes, extreme keys
      burst_mode = 1'b1;
      queue_key_write(CSR_KEY_HIGH, 64'h0123456789abcdef);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_ENCRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_DECRYPT);
      queue_key_write(CSR_KEY_LOW, 64'hfedcba9876543210);
      queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, MODE_ENCRYPT);
      queue_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, MODE_DECRYPT);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_ENCRYPT);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_DECRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_ENCRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_DECRYPT);
      queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, MODE_ENCRYPT);
      queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, MODE_DECRYPT);
      queue_key_write(CSR_SPARE_2, ALL_ONE);
      queue_key_write(CSR_SPARE_3, random_word());
      queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, MODE_ENCRYPT);
      queue_key_write(CSR_KEY_HIGH, ALL_ZERO);
      queue_key_write(CSR_KEY_LOW, ALL_ZERO);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_ENCRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_DECRYPT);
      queue_key_write(CSR_KEY_HIGH, ALL_ONE);
      queue_key_write(CSR_KEY_LOW, ALL_ONE);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_ENCRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_ENCRYPT);
      queue_block(ALL_ONE, ALL_ONE, MODE_DECRYPT);
      queue_block(ALL_ZERO, ALL_ZERO, MODE_DECRYPT);

      for (p = 0; p < 8; p++) begin
         burst_mode = (p % 3 == 0);
         if (p == 0) begin
            high = ALL_ZERO;
            low  = ALL_ONE;
         end else if (p == 1) begin
            high = ALL_ONE;
            low  = ALL_ZERO;
         end else begin
            high = random_word();
            low  = random_word();
         end
         if (p % 4 == 1)
            queue_key_write(($urandom_range(0, 1) == 0) ? CSR_SPARE_2 : CSR_SPARE_3,
                            random_word());
         if (p % 3 == 2) begin
            if ($urandom_range(0, 1) == 0)
               queue_key_write(CSR_KEY_HIGH, high);
            else
               queue_key_write(CSR_KEY_LOW, low);
         end else begin
            queue_key_write(CSR_KEY_HIGH, high);
            queue_key_write(CSR_KEY_LOW, low);
         end
         for (n = 0; n < 73; n++)
            queue_block(random_word(), random_word(),
                        ($urandom_range(0, 1) == 0) ? MODE_ENCRYPT : MODE_DECRYPT);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (stimulus_queue.size() > 0 || start || csr_valid || expected_blocks.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
